// ===== src/msb_first_bit_packer_defines.svh =====
// Assertion macros used by the bit packer top level.
`ifndef MSB_FIRST_BIT_PACKER_DEFINES_SVH
`define MSB_FIRST_BIT_PACKER_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define MFBP_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("mfbp: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define MFBP_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("mfbp: next-cycle check failed");

`endif

// ===== src/mfbp_pkg.sv =====
// Shared types, constants and helpers of the MSB-first bit packer.
package mfbp_pkg;

    localparam int MAX_FIELD_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF    = 4;
    localparam int TOTAL_W            = 32;
    localparam int VALID_W            = 4;

    localparam logic [VALID_W-1:0] FULL_BYTE = 4'd8;

    typedef enum logic [1:0] {
        K_WRITE,
        K_FLUSH,
        K_ERROR
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [VALID_W-1:0]  valid_bits;
        logic [TOTAL_W-1:0]  total;
    } t_job_ctl;

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
        sat_inc = (v == {TOTAL_W{1'b1}}) ? v : v + TOTAL_W'(1);
    endfunction

endpackage

// ===== src/msb_first_bit_packer.sv =====
// Top level of the MSB-first bit packer: front end, job queue and output side.
// An item is taken in every cycle while the job queue has room. A write gives one
// result per completed byte, one per cycle while i_ready is high (up to four for a
// 32-bit field); flush and errors give one. Synchronous active-low reset clears the
// pending bits, fill count, byte total and queue.
`include "msb_first_bit_packer_defines.svh"

module msb_first_bit_packer #(
    parameter int MAX_FIELD_BITS = mfbp_pkg::MAX_FIELD_BITS_DEF,
    parameter int QUEUE_DEPTH    = mfbp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [31:0] i_field_value,
    input  logic [5:0]  i_field_width,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_data_byte,
    output logic [3:0]  o_valid_bits,
    output logic [31:0] o_byte_total,
    output logic        o_status,
    output logic        o_last
);

    localparam int NB  = (MAX_FIELD_BITS + 15) / 8;
    localparam int NBW = $clog2(NB);

    logic                 take;
    logic                 push;
    logic                 pop;
    logic                 q_full;
    logic                 q_empty;
    mfbp_pkg::t_job_ctl   f_ctl;
    logic [NB-1:0][7:0]   f_bytes;
    logic [NBW-1:0]       f_nbytes;
    mfbp_pkg::t_job_ctl   h_ctl;
    logic [NB-1:0][7:0]   h_bytes;
    logic [NBW-1:0]       h_nbytes;

    assign o_ready = !q_full;
    assign take    = i_valid && !q_full;

    mfbp_front #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS),
        .NB             (NB),
        .NBW            (NBW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_action      (i_action),
        .i_field_value (i_field_value),
        .i_field_width (i_field_width),
        .o_push        (push),
        .o_ctl         (f_ctl),
        .o_bytes       (f_bytes),
        .o_nbytes      (f_nbytes)
    );

    mfbp_queue #(
        .DEPTH (QUEUE_DEPTH),
        .NB    (NB),
        .NBW   (NBW)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_ctl    (f_ctl),
        .i_bytes  (f_bytes),
        .i_nbytes (f_nbytes),
        .i_pop    (pop),
        .o_full   (q_full),
        .o_empty  (q_empty),
        .o_ctl    (h_ctl),
        .o_bytes  (h_bytes),
        .o_nbytes (h_nbytes)
    );

    mfbp_back #(
        .NB  (NB),
        .NBW (NBW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_ctl        (h_ctl),
        .i_bytes      (h_bytes),
        .i_nbytes     (h_nbytes),
        .i_ready      (i_ready),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_data_byte  (o_data_byte),
        .o_valid_bits (o_valid_bits),
        .o_byte_total (o_byte_total),
        .o_status     (o_status),
        .o_last       (o_last)
    );

    `MFBP_ASSERT_IMP(a_error_single, o_valid && o_status, o_last && (o_valid_bits == 4'd0))
    `MFBP_ASSERT_IMP(a_partial_last, o_valid && (o_valid_bits != mfbp_pkg::FULL_BYTE), o_last)
    `MFBP_ASSERT_NXT(a_run_continues, o_valid && i_ready && !o_last, o_valid)
    `MFBP_ASSERT_IMP(a_no_overflow, push, !q_full)

endmodule

// ===== src/mfbp_front.sv =====
// Front end: accepts items, classifies them and packs field bits into byte jobs.
module mfbp_front #(
    parameter int MAX_FIELD_BITS = mfbp_pkg::MAX_FIELD_BITS_DEF,
    parameter int NB             = (MAX_FIELD_BITS + 15) / 8,
    parameter int NBW            = $clog2(NB)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic                          i_action,
    input  logic [31:0]                   i_field_value,
    input  logic [5:0]                    i_field_width,
    output logic                          o_push,
    output mfbp_pkg::t_job_ctl            o_ctl,
    output logic [NB-1:0][7:0]            o_bytes,
    output logic [NBW-1:0]                o_nbytes
);

    localparam int WORD_W = 8 * NB;
    localparam int T_W    = $clog2(MAX_FIELD_BITS + 8);
    localparam int SH_W   = $clog2(WORD_W + 1);

    logic [7:0]                    r_pend;
    logic [2:0]                    r_fill;
    logic [mfbp_pkg::TOTAL_W-1:0]  r_count;
    logic [7:0]                    n_pend;
    logic [2:0]                    n_fill;
    logic [mfbp_pkg::TOTAL_W-1:0]  n_count;

    mfbp_pkg::t_kind               kind;
    logic                          illegal;
    logic [MAX_FIELD_BITS-1:0]     v_ext;
    logic [MAX_FIELD_BITS-1:0]     v_mask;
    logic [T_W-1:0]                t_bits;
    logic [SH_W-1:0]               shamt;
    logic [WORD_W-1:0]             word_flat;
    logic [NB-1:0][7:0]            word;
    logic [NBW-1:0]                nbytes;
    logic [mfbp_pkg::TOTAL_W:0]    count_sum;

    assign illegal = (i_field_width == 6'd0) ||
                     (32'(i_field_width) > 32'(MAX_FIELD_BITS));
    assign kind    = i_action ? mfbp_pkg::K_FLUSH :
                     (illegal ? mfbp_pkg::K_ERROR : mfbp_pkg::K_WRITE);

    assign v_ext     = MAX_FIELD_BITS'(i_field_value);
    assign v_mask    = ~({MAX_FIELD_BITS{1'b1}} << i_field_width);
    assign t_bits    = T_W'(r_fill) + T_W'(i_field_width);
    assign shamt     = SH_W'(WORD_W) - SH_W'(i_field_width) - SH_W'(r_fill);
    assign word_flat = (WORD_W'(v_ext & v_mask) << shamt) |
                       {r_pend, {(WORD_W-8){1'b0}}};
    assign word      = word_flat;
    assign nbytes    = NBW'(t_bits >> 3);
    assign count_sum = {1'b0, r_count} + (mfbp_pkg::TOTAL_W + 1)'(nbytes);

    assign n_pend  = word[NBW'(NB - 1) - nbytes];
    assign n_fill  = t_bits[2:0];
    assign n_count = count_sum[mfbp_pkg::TOTAL_W] ? {mfbp_pkg::TOTAL_W{1'b1}}
                                                  : count_sum[mfbp_pkg::TOTAL_W-1:0];

    always_comb begin
        o_ctl.kind       = kind;
        o_ctl.valid_bits = mfbp_pkg::FULL_BYTE;
        o_ctl.total      = r_count;
        o_bytes          = word;
        o_nbytes         = nbytes;
        o_push           = i_take;
        case (kind)
            mfbp_pkg::K_WRITE: begin
                o_push = i_take && (nbytes != '0);
            end
            mfbp_pkg::K_FLUSH: begin
                o_ctl.valid_bits = {1'b0, r_fill};
                o_ctl.total      = (r_fill != 3'd0) ? mfbp_pkg::sat_inc(r_count) : r_count;
                o_bytes          = {r_pend, {(WORD_W-8){1'b0}}};
                o_nbytes         = '0;
            end
            default: begin
                o_ctl.valid_bits = '0;
                o_bytes          = '0;
                o_nbytes         = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_fill  <= '0;
            r_count <= '0;
        end else if (i_take && (kind == mfbp_pkg::K_WRITE)) begin
            r_pend  <= n_pend;
            r_fill  <= n_fill;
            r_count <= n_count;
        end
    end

endmodule

// ===== src/mfbp_queue.sv =====
// Register queue of byte jobs between the front end and the output side.
module mfbp_queue #(
    parameter int DEPTH = mfbp_pkg::QUEUE_DEPTH_DEF,
    parameter int NB    = 5,
    parameter int NBW   = $clog2(NB)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  mfbp_pkg::t_job_ctl     i_ctl,
    input  logic [NB-1:0][7:0]     i_bytes,
    input  logic [NBW-1:0]         i_nbytes,
    input  logic                   i_pop,
    output logic                   o_full,
    output logic                   o_empty,
    output mfbp_pkg::t_job_ctl     o_ctl,
    output logic [NB-1:0][7:0]     o_bytes,
    output logic [NBW-1:0]         o_nbytes
);

    localparam int PTR_W = $clog2(DEPTH);

    mfbp_pkg::t_job_ctl   r_ctl    [DEPTH];
    logic [NB-1:0][7:0]   r_bytes  [DEPTH];
    logic [NBW-1:0]       r_nbytes [DEPTH];
    logic [PTR_W-1:0]     r_wr;
    logic [PTR_W-1:0]     r_rd;
    logic [PTR_W:0]       r_cnt;

    assign o_full   = (r_cnt == (PTR_W + 1)'(DEPTH));
    assign o_empty  = (r_cnt == '0);
    assign o_ctl    = r_ctl[r_rd];
    assign o_bytes  = r_bytes[r_rd];
    assign o_nbytes = r_nbytes[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ctl[r_wr]    <= i_ctl;
            r_bytes[r_wr]  <= i_bytes;
            r_nbytes[r_wr] <= i_nbytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (PTR_W + 1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (PTR_W + 1)'(1);
            end
        end
    end

endmodule

// ===== src/mfbp_back.sv =====
// Output side: emits the head job's bytes, one per cycle unless stalled.
module mfbp_back #(
    parameter int NB  = 5,
    parameter int NBW = $clog2(NB)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  mfbp_pkg::t_job_ctl            i_ctl,
    input  logic [NB-1:0][7:0]            i_bytes,
    input  logic [NBW-1:0]                i_nbytes,
    input  logic                          i_ready,
    output logic                          o_pop,
    output logic                          o_valid,
    output logic [7:0]                    o_data_byte,
    output logic [3:0]                    o_valid_bits,
    output logic [31:0]                   o_byte_total,
    output logic                          o_status,
    output logic                          o_last
);

    logic                          r_valid;
    logic [NBW-1:0]                r_idx;
    logic [mfbp_pkg::TOTAL_W-1:0]  r_run;
    logic [7:0]                    r_byte;
    logic [3:0]                    r_vbits;
    logic [31:0]                   r_total;
    logic                          r_status;
    logic                          r_last;

    logic                          adv;
    logic                          is_write;
    logic                          cur_last;
    logic [mfbp_pkg::TOTAL_W-1:0]  cur_total;

    assign adv       = !i_empty && (!r_valid || i_ready);
    assign is_write  = (i_ctl.kind == mfbp_pkg::K_WRITE);
    assign cur_last  = !is_write || ((r_idx + NBW'(1)) == i_nbytes);
    assign cur_total = is_write ?
                       mfbp_pkg::sat_inc((r_idx == '0) ? i_ctl.total : r_run) :
                       i_ctl.total;
    assign o_pop     = adv && cur_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (adv) begin
            r_valid <= 1'b1;
            r_idx   <= cur_last ? '0 : r_idx + NBW'(1);
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_run    <= cur_total;
            r_byte   <= i_bytes[NBW'(NB - 1) - r_idx];
            r_vbits  <= i_ctl.valid_bits;
            r_total  <= cur_total;
            r_status <= (i_ctl.kind == mfbp_pkg::K_ERROR);
            r_last   <= cur_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_data_byte  = r_byte;
    assign o_valid_bits = r_vbits;
    assign o_byte_total = r_total;
    assign o_status     = r_status;
    assign o_last       = r_last;

endmodule
